>>> src/vmt_pkg.sv
// Shared types and constants for the vector-matrix transform block.
package vmt_pkg;

  localparam int unsigned NUM_ROWS  = 4;
  localparam int unsigned NUM_COLS  = 4;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned REG_W     = 64;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned PAIR_W    = 65;
  localparam int unsigned SUM_W     = 66;

  localparam logic [1:0] MODE_2D = 2'd0;
  localparam logic [1:0] MODE_3D = 2'd1;
  localparam logic [1:0] MODE_4D = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW1_PAIR_A = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW4_PAIR_B = 4'd7;

  localparam logic [REG_W-1:0] COEF_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  localparam logic signed [COEF_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [COEF_W-1:0] in_x;
    logic signed [COEF_W-1:0] in_y;
    logic signed [COEF_W-1:0] in_z;
    logic signed [COEF_W-1:0] in_w;
  } vmt_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_x;
    logic signed [COEF_W-1:0] out_y;
    logic signed [COEF_W-1:0] out_z;
    logic signed [COEF_W-1:0] out_w;
    logic                     overflow;
  } vmt_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;
  } vmt_cfg_t;

endpackage

>>> src/vmt_stream_if.sv
// Valid/ready channel carrying one payload word per request.
interface vmt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/vector_matrix_transform.sv
// Top level: pipelined 4x4 matrix times vector in signed fixed point.
//
// in_req  : sink channel, one vector request (mode, in_x..in_w) per accepted beat.
// out_res : source channel, one result (out_x..out_w, overflow) per request,
//           delivered in request order.
// cfg_wr  : sink channel, writes coefficient register 'index' with 'data';
//           always ready, indexes beyond the last register are dropped.
//           Write only while no request is in flight.
// Pipeline: four register stages (products, pair sums, row sums, shift and
// saturate), which an accepted request passes to reach out_res.valid. While
// out_res is ready, one request is taken every cycle; throughput is set by
// the 16 parallel 32x32 multipliers of the first stage.
// Each stage advances when its successor can take data, so bubbles fill and
// a stalled out_res holds every stage in place without loss or repetition;
// in_req.ready drops only once all four stages hold requests.
// Reset: synchronous, active low; empties the pipeline and loads the
// identity matrix into the coefficient registers.
module vector_matrix_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  vmt_stream_if.sink   in_req,
  vmt_stream_if.source out_res,
  vmt_stream_if.sink   cfg_wr
);

  localparam int unsigned HI_W = vmt_pkg::SUM_W - vmt_pkg::COEF_W + 1;

  logic [vmt_pkg::REG_W-1:0] coef_regs_r [vmt_pkg::NUM_REGS];
  logic signed [vmt_pkg::COEF_W-1:0] coef [vmt_pkg::NUM_ROWS][vmt_pkg::NUM_COLS];
  logic signed [vmt_pkg::COEF_W-1:0] comp [vmt_pkg::NUM_COLS];

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_en, s2_en, s3_en, s4_en;
  logic [1:0] s1_mode_r, s2_mode_r, s3_mode_r;

  logic signed [vmt_pkg::PROD_W-1:0] prod_r   [vmt_pkg::NUM_ROWS][vmt_pkg::NUM_COLS];
  logic signed [vmt_pkg::PROD_W-1:0] prod_nxt [vmt_pkg::NUM_ROWS][vmt_pkg::NUM_COLS];
  logic signed [vmt_pkg::PAIR_W-1:0] pair_r   [vmt_pkg::NUM_ROWS][2];
  logic signed [vmt_pkg::PAIR_W-1:0] pair_nxt [vmt_pkg::NUM_ROWS][2];
  logic signed [vmt_pkg::SUM_W-1:0]  sum_r    [vmt_pkg::NUM_ROWS];
  logic signed [vmt_pkg::SUM_W-1:0]  sum_nxt  [vmt_pkg::NUM_ROWS];

  logic signed [vmt_pkg::SUM_W-1:0]  shifted  [vmt_pkg::NUM_ROWS];
  logic signed [vmt_pkg::COEF_W-1:0] sat      [vmt_pkg::NUM_ROWS];
  logic [vmt_pkg::NUM_ROWS-1:0]      row_ovf;
  logic [vmt_pkg::NUM_ROWS-1:0]      row_used;
  logic z_used, w_used;

  vmt_pkg::vmt_out_t res_r, res_nxt;

  // handshake chain
  assign s4_en         = !s4_valid_r || out_res.ready;
  assign s3_en         = !s3_valid_r || s4_en;
  assign s2_en         = !s2_valid_r || s3_en;
  assign s1_en         = !s1_valid_r || s2_en;
  assign in_req.ready  = s1_en;
  assign cfg_wr.ready  = 1'b1;
  assign out_res.valid = s4_valid_r;
  assign out_res.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vmt_pkg::NUM_REGS; i++) begin
        coef_regs_r[i] <= vmt_pkg::COEF_RESET[i];
      end
    end else if (cfg_wr.valid && cfg_wr.data.index <= vmt_pkg::REG_ROW4_PAIR_B) begin
      coef_regs_r[cfg_wr.data.index[2:0]] <= cfg_wr.data.data;
    end
  end

  // stage 1: masked components times coefficients
  assign z_used = in_req.data.mode != vmt_pkg::MODE_2D;
  assign w_used = z_used && in_req.data.mode != vmt_pkg::MODE_3D;

  always_comb begin
    comp[0] = in_req.data.in_x;
    comp[1] = in_req.data.in_y;
    comp[2] = z_used ? in_req.data.in_z : '0;
    comp[3] = w_used ? in_req.data.in_w : '0;
    for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < vmt_pkg::NUM_COLS; c++) begin
        coef[r][c] = coef_regs_r[2*r + c/2][vmt_pkg::COEF_W*(c%2) +: vmt_pkg::COEF_W];
        prod_nxt[r][c] = coef[r][c] * comp[c];
      end
    end
  end

  // stage 2 and 3: adder tree per row
  always_comb begin
    for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
      for (int h = 0; h < 2; h++) begin
        pair_nxt[r][h] = {prod_r[r][2*h][vmt_pkg::PROD_W-1], prod_r[r][2*h]}
                       + {prod_r[r][2*h+1][vmt_pkg::PROD_W-1], prod_r[r][2*h+1]};
      end
      sum_nxt[r] = {pair_r[r][0][vmt_pkg::PAIR_W-1], pair_r[r][0]}
                 + {pair_r[r][1][vmt_pkg::PAIR_W-1], pair_r[r][1]};
    end
  end

  // stage 4: shift, saturate, zero unused rows
  assign row_used[0] = 1'b1;
  assign row_used[1] = 1'b1;
  assign row_used[2] = s3_mode_r != vmt_pkg::MODE_2D;
  assign row_used[3] = row_used[2] && s3_mode_r != vmt_pkg::MODE_3D;

  always_comb begin
    for (int r = 0; r < vmt_pkg::NUM_ROWS; r++) begin
      shifted[r] = sum_r[r] >>> FRAC_BITS;
      if (!shifted[r][vmt_pkg::SUM_W-1] &&
          (|shifted[r][vmt_pkg::SUM_W-1 -: HI_W])) begin
        sat[r]     = vmt_pkg::SAT_MAX;
        row_ovf[r] = row_used[r];
      end else if (shifted[r][vmt_pkg::SUM_W-1] &&
                   !(&shifted[r][vmt_pkg::SUM_W-1 -: HI_W])) begin
        sat[r]     = vmt_pkg::SAT_MIN;
        row_ovf[r] = row_used[r];
      end else begin
        sat[r]     = shifted[r][vmt_pkg::COEF_W-1:0];
        row_ovf[r] = 1'b0;
      end
      if (!row_used[r]) begin
        sat[r] = '0;
      end
    end
    res_nxt.out_x    = sat[0];
    res_nxt.out_y    = sat[1];
    res_nxt.out_z    = sat[2];
    res_nxt.out_w    = sat[3];
    res_nxt.overflow = |row_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_req.valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_en) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_mode_r <= in_req.data.mode;
      prod_r    <= prod_nxt;
    end
    if (s2_en) begin
      s2_mode_r <= s1_mode_r;
      pair_r    <= pair_nxt;
    end
    if (s3_en) begin
      s3_mode_r <= s2_mode_r;
      sum_r     <= sum_nxt;
    end
    if (s4_en) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench for the 4x4 fixed-point vector-matrix transform block.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned COEF_W = vmt_pkg::COEF_W;
  localparam int unsigned CFG_IDX_W = vmt_pkg::CFG_IDX_W;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef logic [vmt_pkg::REG_W-1:0] coef_bank_t [vmt_pkg::NUM_REGS];
  typedef logic [COEF_W-1:0] coef_list_t [vmt_pkg::NUM_ROWS*vmt_pkg::NUM_COLS];
  typedef enum int {DRAW_SMALL, DRAW_FULL, DRAW_EDGE, DRAW_MIXED} draw_style_t;

  logic clk;
  logic rst_n;

  vmt_stream_if #(.payload_t(vmt_pkg::vmt_in_t))  in_req ();
  vmt_stream_if #(.payload_t(vmt_pkg::vmt_out_t)) out_res ();
  vmt_stream_if #(.payload_t(vmt_pkg::vmt_cfg_t)) cfg_wr ();

  vector_matrix_transform #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  coef_bank_t          coef_bank;
  vmt_pkg::vmt_out_t   pending_results [$];
  vmt_pkg::vmt_out_t   oldest_result;
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned stall_left;
  int unsigned err_count;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_cfg;
  int unsigned n_overflow;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(99) < 80) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [COEF_W-1:0] draw_word(input draw_style_t style);
    logic [COEF_W-1:0] edges [7];
    edges = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000,
              32'hffff_0000, 32'h0000_0001, 32'hffff_ffff};
    if (style == DRAW_MIXED) style = draw_style_t'($urandom_range(0, 2));
    case (style)
      DRAW_SMALL: return COEF_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      DRAW_EDGE:  return edges[$urandom_range(0, 6)];
      default:    return $urandom;
    endcase
  endfunction

  function automatic coef_bank_t pack_matrix(input coef_list_t c);
    coef_bank_t m;
    for (int r = 0; r < int'(vmt_pkg::NUM_ROWS); r++) begin
      m[2*r]     = {c[4*r+1], c[4*r]};
      m[2*r + 1] = {c[4*r+3], c[4*r+2]};
    end
    return m;
  endfunction

  function automatic coef_bank_t identity_matrix();
    return pack_matrix('{32'h10000, 0, 0, 0,  0, 32'h10000, 0, 0,
                         0, 0, 32'h10000, 0,  0, 0, 0, 32'h10000});
  endfunction

  function automatic coef_bank_t random_matrix(input draw_style_t style);
    coef_list_t c;
    foreach (c[i]) c[i] = draw_word(style);
    return pack_matrix(c);
  endfunction

  function automatic vmt_pkg::vmt_in_t random_vector(input draw_style_t style);
    vmt_pkg::vmt_in_t v;
    v.mode = 2'($urandom_range(0, 3));
    v.in_x = draw_word(style);
    v.in_y = draw_word(style);
    v.in_z = draw_word(style);
    v.in_w = draw_word(style);
    return v;
  endfunction

  function automatic vmt_pkg::vmt_in_t make_vector(input logic [1:0] mode,
                                                   input logic [31:0] x,
                                                   input logic [31:0] y,
                                                   input logic [31:0] z,
                                                   input logic [31:0] w);
    vmt_pkg::vmt_in_t v;
    v.mode = mode;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  function automatic vmt_pkg::vmt_out_t transform_vector(input vmt_pkg::vmt_in_t v);
    logic signed [COEF_W-1:0]          comp [vmt_pkg::NUM_COLS];
    logic signed [COEF_W-1:0]          dot [vmt_pkg::NUM_ROWS];
    logic signed [COEF_W-1:0]          c;
    logic signed [vmt_pkg::PROD_W-1:0] prod;
    logic signed [vmt_pkg::SUM_W-1:0]  acc;
    logic signed [vmt_pkg::SUM_W-1:0]  scaled;
    logic [vmt_pkg::REG_W-1:0]         pair;
    logic                              ovf;
    int                                n;
    vmt_pkg::vmt_out_t                 r;
    comp = '{v.in_x, v.in_y, v.in_z, v.in_w};
    n = (v.mode == vmt_pkg::MODE_2D) ? 2 : (v.mode == vmt_pkg::MODE_3D) ? 3 : 4;
    ovf = 1'b0;
    for (int row = 0; row < int'(vmt_pkg::NUM_ROWS); row++) begin
      dot[row] = '0;
      if (row < n) begin
        acc = '0;
        for (int col = 0; col < n; col++) begin
          pair = coef_bank[2*row + col/2];
          c = (col % 2) ? pair[63:32] : pair[31:0];
          prod = c * comp[col];
          acc = acc + prod;
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > vmt_pkg::SAT_MAX) begin
          dot[row] = vmt_pkg::SAT_MAX;
          ovf = 1'b1;
        end else if (scaled < vmt_pkg::SAT_MIN) begin
          dot[row] = vmt_pkg::SAT_MIN;
          ovf = 1'b1;
        end else begin
          dot[row] = scaled[COEF_W-1:0];
        end
      end
    end
    r.out_x = dot[0];
    r.out_y = dot[1];
    r.out_z = dot[2];
    r.out_w = dot[3];
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input vmt_pkg::vmt_out_t got, input vmt_pkg::vmt_out_t want);
    logic [COEF_W-1:0] g [5];
    logic [COEF_W-1:0] w [5];
    string             names [5];
    g = '{got.out_x, got.out_y, got.out_z, got.out_w, COEF_W'(got.overflow)};
    w = '{want.out_x, want.out_y, want.out_z, want.out_w, COEF_W'(want.overflow)};
    names = '{"out_x", "out_y", "out_z", "out_w", "overflow"};
    for (int i = 0; i < 5; i++) begin
      if (g[i] !== w[i])
        report_mismatch($sformatf("result %0d %s got %h want %h", n_checked, names[i],
                                  g[i], w[i]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_res.ready <= 1'b0;
      stall_left--;
    end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
      out_res.ready <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", out_res.data));
      end else begin
        oldest_result = pending_results.pop_front();
        check_result(out_res.data, oldest_result);
        if (oldest_result.overflow) n_overflow++;
        n_checked++;
      end
    end
  end

  task automatic send_vector(input vmt_pkg::vmt_in_t v);
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_req.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data <= v;
    do @(posedge clk); while (!in_req.ready);
    pending_results.push_back(transform_vector(v));
    n_sent++;
  endtask

  task automatic drain_pipeline();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_matrix(input coef_bank_t m, input bit stray);
    logic [CFG_IDX_W-1:0]      idx;
    logic [vmt_pkg::REG_W-1:0] val;
    drain_pipeline();
    for (int k = stray ? -1 : 0; k < int'(vmt_pkg::NUM_REGS); k++) begin
      if (k < 0) begin
        idx = CFG_IDX_W'($urandom_range(vmt_pkg::REG_ROW4_PAIR_B + 1,
                                        (1 << CFG_IDX_W) - 1));
        val = {$urandom, $urandom};
      end else begin
        idx = vmt_pkg::REG_ROW1_PAIR_A + CFG_IDX_W'(k);
        val = m[k];
      end
      cfg_wr.valid <= 1'b1;
      cfg_wr.data <= '{index: idx, data: val};
      do @(posedge clk); while (!cfg_wr.ready);
      if (idx <= vmt_pkg::REG_ROW4_PAIR_B) coef_bank[idx[2:0]] = val;
      n_cfg++;
    end
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_identity_reset();
    in_gap_pct = 20;
    out_stall_pct = 20;
    send_vector(make_vector(vmt_pkg::MODE_2D, 32'h0001_0000, 32'hffff_0000, 32'h7fff_ffff,
                            32'h8000_0000));
    send_vector(make_vector(vmt_pkg::MODE_3D, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                            32'h7fff_ffff));
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h7fff_ffff));
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000));
    send_vector(make_vector(MODE_SPARE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                            32'h0004_0000));
    send_vector(make_vector(vmt_pkg::MODE_4D, 0, 0, 0, 0));
  endtask

  task automatic test_register_map();
    load_matrix(pack_matrix('{32'h0000_8000, 32'hffff_8000, 32'h0002_0000, 32'hffff_ffff,
                              32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                              32'h7fff_ffff, 32'h0000_0000, 32'hffff_0000, 32'h0000_0001,
                              32'h8000_0000, 32'h0003_0000, 32'h0000_0000, 32'h0000_4000}),
                1'b1);
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'hffff_ffff, 32'h0000_0001, 32'hffff_0000,
                            32'h1234_5678));
    send_vector(make_vector(vmt_pkg::MODE_3D, 32'h0001_0000, 32'hfffe_0000, 32'h0000_0003,
                            32'h7fff_ffff));
    send_vector(make_vector(vmt_pkg::MODE_2D, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0005,
                            32'h0000_0006));
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h0001_8000, 32'hffff_fffd, 32'h0000_0007,
                            32'hffff_0000));
  endtask

  task automatic test_saturation();
    coef_list_t c;
    foreach (c[i]) c[i] = 32'h7fff_ffff;
    load_matrix(pack_matrix(c), 1'b0);
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h7fff_ffff));
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000));
    foreach (c[i]) c[i] = 32'h8000_0000;
    load_matrix(pack_matrix(c), 1'b0);
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000));
    send_vector(make_vector(vmt_pkg::MODE_2D, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                            32'h8000_0000));
    load_matrix(pack_matrix('{32'h0001_0000, 32'h0001_0000, 0, 0,
                              0, 32'h0001_0000, 0, 0,
                              0, 0, 32'h0001_0000, 0,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}),
                1'b0);
    send_vector(make_vector(vmt_pkg::MODE_2D, 32'h7fff_ffff, 32'h0000_0001, 0, 0));
    send_vector(make_vector(vmt_pkg::MODE_3D, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000));
    send_vector(make_vector(vmt_pkg::MODE_4D, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000));
  endtask

  task automatic test_random_stream();
    draw_style_t mat_style [5];
    draw_style_t vec_style [5];
    int unsigned gaps [5];
    int unsigned stalls [5];
    coef_bank_t  m;
    mat_style = '{DRAW_SMALL, DRAW_FULL, DRAW_MIXED, DRAW_EDGE, DRAW_SMALL};
    vec_style = '{DRAW_MIXED, DRAW_FULL, DRAW_MIXED, DRAW_MIXED, DRAW_SMALL};
    gaps      = '{30, 0, 50, 15, 10};
    stalls    = '{30, 0, 60, 15, 70};
    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        m = identity_matrix();
      end else begin
        m = random_matrix(mat_style[p]);
      end
      load_matrix(m, 1'($urandom_range(0, 1)));
      in_gap_pct = gaps[p];
      out_stall_pct = stalls[p];
      repeat (80) send_vector(random_vector(vec_style[p]));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.data = '0;
    out_res.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.data = '0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    err_count = 0;
    n_sent = 0;
    n_checked = 0;
    n_cfg = 0;
    n_overflow = 0;
    coef_bank = identity_matrix();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity_reset();
    test_register_map();
    test_saturation();
    test_random_stream();

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d vectors over 2-, 3- and 4-component modes, checked %0d results",
             n_sent, n_checked);
    $display("%0d saturated, %0d coefficient writes across 9 matrix settings",
             n_overflow, n_cfg);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
